// ----- src/sorted_priority_queue_assert.svh -----
// assertion macros for the sorted priority queue
// used by the top level, expects clk_i and rst_ni in scope
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 4;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [KEY_W-1:0]          key;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e op;
    entry_t   entry;
  } cell_ctrl_t;

endpackage

// ----- src/sorted_priority_queue.sv -----
// Sorted priority queue of DEPTH entries (value, key), smallest key at the head.
// The store is a chain of identical cells, cell 0 holding the head. An enqueue
// broadcasts the new key to all cells at once: every occupied cell whose key is
// equal or smaller keeps its entry, the first cell past them takes the new entry
// and every cell behind it takes its lower neighbor's entry, so equal keys leave
// in arrival order. A dequeue returns cell 0 and every cell takes its upper
// neighbor's entry. An enqueue into a full queue reports overflow and a dequeue
// from an empty queue reports underflow; neither changes the queue. Rate: one
// item per cycle, the chain updates in the cycle of acceptance and the result
// sits in an output register the next cycle; in_ready_o stays high while that
// register is empty or being taken. Occupancy is the entry count after the step,
// truncated to 4 bits. No clearing pass is needed after reset.
// depends on spq_pkg, spq_cell and sorted_priority_queue_assert.svh
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               opcode_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] item_value_i,
  input  logic [spq_pkg::KEY_W-1:0]          item_key_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [spq_pkg::STAT_W-1:0]         status_o,
  output logic signed [spq_pkg::VALUE_W-1:0] head_value_o,
  output logic [spq_pkg::KEY_W-1:0]          head_key_o,
  output logic [spq_pkg::OCC_W-1:0]          occupancy_o
);
  import spq_pkg::*;

  // entry count, the only control state of the store
  logic [CNT_W-1:0] count_q, count_d;

  // result register
  logic                      out_valid_q, out_valid_d;
  status_e                   status_q, status_d;
  logic signed [VALUE_W-1:0] head_value_q, head_value_d;
  logic [KEY_W-1:0]          head_key_q, head_key_d;
  logic [OCC_W-1:0]          occ_q;

  logic       in_fire;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  // chain wiring
  entry_t     cell_entry [DEPTH];
  entry_t     prev_entry [DEPTH];
  entry_t     next_entry [DEPTH];
  logic [DEPTH-1:0] stay;
  logic [DEPTH-1:0] prev_stay;
  logic [DEPTH-1:0] occ;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  // decode of the accepted item
  always_comb begin
    ctrl.op          = CELL_HOLD;
    ctrl.entry.value = item_value_i;
    ctrl.entry.key   = item_key_i;
    count_d          = count_q;
    status_d         = ST_OK;
    head_value_d     = '0;
    head_key_d       = '0;
    if (in_fire) begin
      case (opcode_e'(opcode_i))
        OP_ENQUEUE: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            ctrl.op = CELL_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_DEQUEUE: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            ctrl.op      = CELL_SHIFT;
            head_value_d = cell_entry[0].value;
            head_key_d   = cell_entry[0].key;
            count_d      = count_q - CNT_W'(1);
          end
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
    end
  end

  // the chain of cells; ends are tied off
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      // head cell always takes the new entry when it gives way
      assign prev_stay[i]  = 1'b1;
      assign prev_entry[i] = '0;
    end else begin : g_body
      assign prev_stay[i]  = stay[i-1];
      assign prev_entry[i] = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // past the tail nothing is stored
      assign next_entry[i] = '0;
    end else begin : g_inner
      assign next_entry[i] = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[i]),
      .prev_stay_i  (prev_stay[i]),
      .prev_entry_i (prev_entry[i]),
      .next_entry_i (next_entry[i]),
      .stay_o       (stay[i]),
      .entry_o      (cell_entry[i])
    );
  end

  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q     <= status_d;
      head_value_q <= head_value_d;
      head_key_q   <= head_key_d;
      occ_q        <= OCC_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign head_value_o = head_value_q;
  assign head_key_o   = head_key_q;
  assign occupancy_o  = occ_q;

  // checks
  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count exceeds depth")
  `SPQ_ASSERT_NXT(a_overflow_hold, in_fire && (opcode_i == OP_ENQUEUE) && full, $stable(count_q), "overflow changed count")
  `SPQ_ASSERT_NXT(a_result_follows, in_fire, out_valid_q, "accepted item gave no result")

  for (genvar j = 1; j < DEPTH; j++) begin : g_chk
    `SPQ_ASSERT_IMP(a_sorted, occ[j], cell_entry[j-1].key <= cell_entry[j].key, "chain out of order")
  end

endmodule

// ----- src/spq_cell.sv -----
// one slot of the sorted chain: holds an entry, compares with the broadcast key
// depends on spq_pkg
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic               prev_stay_i,
  input  spq_pkg::entry_t    prev_entry_i,
  input  spq_pkg::entry_t    next_entry_i,
  output logic               stay_o,
  output spq_pkg::entry_t    entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // stored entry is ahead of the new one (equal keys keep arrival order)
  assign stay_o = occ_i && (entry_q.key <= ctrl_i.entry.key);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (stay_o) begin
          entry_d = entry_q;
        end else if (prev_stay_i) begin
          entry_d = ctrl_i.entry;
        end else begin
          entry_d = prev_entry_i;
        end
      end
      CELL_SHIFT: begin
        entry_d = next_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- sim/sorted_priority_queue_checker.sv -----
// scoreboard for the sorted priority queue: watches both channels and checks each result
// keeps its own sorted store of (value, key) entries; depends on spq_pkg
`timescale 1ns / 1ps

module sorted_priority_queue_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               opcode_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] item_value_i,
  input  logic [spq_pkg::KEY_W-1:0]          item_key_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [spq_pkg::STAT_W-1:0]         status_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] head_value_i,
  input  logic [spq_pkg::KEY_W-1:0]          head_key_i,
  input  logic [spq_pkg::OCC_W-1:0]          occupancy_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);
  import spq_pkg::*;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] value;
    logic [KEY_W-1:0]          key;
    logic [OCC_W-1:0]          occupancy;
  } head_report_t;

  entry_t       slots [DEPTH];
  int unsigned  stored;
  head_report_t head_reports [$];
  int unsigned  mismatches;

  // one queue operation on the shadow store, returns the report it should produce
  function automatic head_report_t apply_queue_op(opcode_e op,
                                                  logic signed [VALUE_W-1:0] value,
                                                  logic [KEY_W-1:0] key);
    head_report_t rep;
    int unsigned  pos;
    rep = '0;
    rep.status = ST_OK;
    if (op == OP_ENQUEUE) begin
      if (stored >= DEPTH) begin
        rep.status = ST_OVERFLOW;
      end else begin
        // new entry goes behind every entry of equal or smaller key
        pos = stored;
        while (pos > 0 && slots[pos-1].key > key) begin
          slots[pos] = slots[pos-1];
          pos--;
        end
        slots[pos].value = value;
        slots[pos].key   = key;
        stored++;
      end
    end else begin
      if (stored == 0) begin
        rep.status = ST_UNDERFLOW;
      end else begin
        rep.value = slots[0].value;
        rep.key   = slots[0].key;
        for (int i = 1; i < stored; i++) slots[i-1] = slots[i];
        stored--;
      end
    end
    rep.occupancy = OCC_W'(stored);
    return rep;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    head_report_t want;
    if (!rst_ni) begin
      stored = 0;
      head_reports.delete();
      mismatches = 0;
    end else begin
      // items first, so a same-cycle result would still find its report
      if (in_valid_i && in_ready_i) begin
        head_reports.push_back(apply_queue_op(opcode_e'(opcode_i), item_value_i, item_key_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (head_reports.size() == 0) begin
          $display("%0t: result with nothing pending, actual status %0h value %0h key %0h",
                   $time, status_i, head_value_i, head_key_i);
          mismatches++;
        end else begin
          want = head_reports.pop_front();
          compare_field("status", 32'(want.status), 32'(status_i));
          compare_field("head_value", 32'(want.value), 32'(head_value_i));
          compare_field("head_key", 32'(want.key), 32'(head_key_i));
          compare_field("occupancy", 32'(want.occupancy), 32'(occupancy_i));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= 32'(head_reports.size());
  end

endmodule

// ----- sim/sorted_priority_queue_tb.sv -----
// top of the sorted priority queue testbench: clock, reset, stimulus and verdict
// drives the block and hands both channels to sorted_priority_queue_checker; uses spq_pkg
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1950;
  // bound for the watchdog, leaving lots of room for the slowest run
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 8;

  // receiver behavior for one stretch of cycles
  typedef enum int unsigned {
    RX_STREAM,
    RX_LIGHT,
    RX_HEAVY,
    RX_CHOKE
  } rx_mode_e;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic                      opcode_i     = OP_ENQUEUE;
  logic signed [VALUE_W-1:0] item_value_i = '0;
  logic [KEY_W-1:0]          item_key_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic [STAT_W-1:0]         status_o;
  logic signed [VALUE_W-1:0] head_value_o;
  logic [KEY_W-1:0]          head_key_o;
  logic [OCC_W-1:0]          occupancy_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // sender pacing: items left in the current burst
  int unsigned burst_left = 0;

  // receiver pacing
  rx_mode_e    rx_mode   = RX_STREAM;
  int unsigned rx_left   = 0;

  always #5 clk_i = ~clk_i;

  sorted_priority_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .item_value_i (item_value_i),
    .item_key_i   (item_key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .head_value_o (head_value_o),
    .head_key_o   (head_key_o),
    .occupancy_o  (occupancy_o)
  );

  sorted_priority_queue_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .opcode_i     (opcode_i),
    .item_value_i (item_value_i),
    .item_key_i   (item_key_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .head_value_i (head_value_o),
    .head_key_i   (head_key_o),
    .occupancy_i  (occupancy_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: picks a stall style for a random stretch, then applies it every cycle
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 60);
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM: out_ready_i <= 1'b1;
      RX_LIGHT:  out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:  out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // called at a falling edge; at the start of a burst drops valid for a random gap
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // some bursts follow straight on, giving long stretches without idling
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  // present one item, hold it until accepted, return at the next falling edge
  task automatic send_item(opcode_e op, logic signed [VALUE_W-1:0] value,
                           logic [KEY_W-1:0] key);
    pace_sender();
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    item_value_i <= value;
    item_key_i   <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off the sender until every pending result has been taken
  task automatic wait_queue_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random item value, with the signed extremes now and then
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // random key, mostly from a narrow range so that ties are common
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1:    return KEY_W'($urandom_range(0, 7));
      2:       return KEY_W'($urandom_range(0, 255));
      default: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned enq_pct;
    opcode_e     op;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: underflow on an empty queue
    send_item(OP_DEQUEUE, 32'sh1234_5678, 8'h5a);
    // fill to capacity with key extremes, value extremes and a run of equal keys
    send_item(OP_ENQUEUE, 32'sh7fff_ffff, 8'hff);
    send_item(OP_ENQUEUE, 32'sh8000_0000, 8'h00);
    send_item(OP_ENQUEUE, 32'sh0000_0001, 8'h80);
    send_item(OP_ENQUEUE, 32'sh0000_0002, 8'h80);
    send_item(OP_ENQUEUE, 32'sh0000_0003, 8'h80);
    send_item(OP_ENQUEUE, -32'sd1,        8'h00);
    send_item(OP_ENQUEUE, 32'sh0000_0000, 8'hff);
    send_item(OP_ENQUEUE, 32'sh5555_aaaa, 8'h01);
    // queue full: overflow, nothing stored
    send_item(OP_ENQUEUE, 32'shdead_beef, 8'h00);
    // drain in key order, equal keys in arrival order
    repeat (DEPTH) send_item(OP_DEQUEUE, 32'shffff_ffff, 8'hff);
    // empty again: underflow
    send_item(OP_DEQUEUE, 32'sh0, 8'h00);
    // interleaved insert and remove around a single entry
    send_item(OP_ENQUEUE, 32'shaaaa_5555, 8'h7f);
    send_item(OP_ENQUEUE, 32'sh0f0f_f0f0, 8'h7f);
    send_item(OP_DEQUEUE, 32'sh0, 8'h00);
    send_item(OP_ENQUEUE, 32'shf0f0_0f0f, 8'h7e);
    send_item(OP_DEQUEUE, 32'sh0, 8'h00);
    send_item(OP_DEQUEUE, 32'sh0, 8'h00);

    // random: the enqueue share changes every so often, so the queue
    // swings between empty and full and spends time at both ends
    enq_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 4))
          0:       enq_pct = 10;
          1:       enq_pct = 30;
          2:       enq_pct = 50;
          3:       enq_pct = 70;
          default: enq_pct = 90;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) wait_queue_drained();
      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      send_item(op, pick_value(), pick_key());
    end

    wait_queue_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
sim/sorted_priority_queue_checker.sv
sim/sorted_priority_queue_tb.sv
